>>> design/last_note_priority_key_stack_top_assert.svh
// Assertion macros for the key stack block.
// Used by last_note_priority_key_stack_top.sv; no other dependencies.
`ifndef LAST_NOTE_PRIORITY_KEY_STACK_TOP_ASSERT_SVH
`define LAST_NOTE_PRIORITY_KEY_STACK_TOP_ASSERT_SVH

`ifndef SYNTH
`define LNPKS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LNPKS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LNPKS_ASSERT(label, clk, rst_n, prop, msg)
`define LNPKS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> design/lnpks_pkg.sv
// Shared constants, types and states for the key stack block.
// No dependencies; imported by lnpks_sdiv and last_note_priority_key_stack_top.
`default_nettype none

package lnpks_pkg;

  localparam int unsigned STACK_DEPTH        = 8;
  localparam int unsigned SAMPLES_PER_PERIOD = 32;
  localparam int unsigned NUM_KEYS           = 8;
  localparam int unsigned KEY_W              = 3;
  localparam int unsigned FREQ_W             = 15;
  localparam logic [FREQ_W-1:0] FREQ_RESET   = 15'd440;
  localparam int unsigned DAC_CLOCK_HZ       = 25 * 1000000;
  localparam int unsigned TIMEOUT_W          = 25;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int unsigned DIVIDEND  = DAC_CLOCK_HZ / SAMPLES_PER_PERIOD;
  localparam int unsigned DIVD_W    = $clog2(DIVIDEND + 1);
  localparam int unsigned REM_W     = FREQ_W + 1;
  localparam int unsigned BITCNT_W  = $clog2(DIVD_W + 1);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

>>> design/lnpks_sdiv.sv
// Bit-serial restoring divider: fixed dividend over a key frequency.
// Depends on lnpks_pkg.
`default_nettype none

module lnpks_sdiv (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lnpks_pkg::div_req_t  req_i,
  output lnpks_pkg::div_rsp_t       rsp_o
);
  import lnpks_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [BITCNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [DIVD_W-1:0]   quo_q, quo_d;
  logic [FREQ_W-1:0]   div_q, div_d;

  logic [REM_W-1:0]    trial;
  logic                ge;

  assign trial = {rem_q[REM_W-2:0], quo_q[DIVD_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = BITCNT_W'(DIVD_W);
      rem_d  = '0;
      quo_d  = DIVD_W'(DIVIDEND);
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift one dividend bit in, subtract when it fits
      rem_d = ge ? (trial - {1'b0, div_q}) : trial;
      quo_d = {quo_q[DIVD_W-2:0], ge};
      cnt_d = cnt_q - BITCNT_W'(1);
      if (cnt_q == BITCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

>>> design/last_note_priority_key_stack_top.sv
// Last-note-priority key stack: held-key stack, frequency registers, result word.
// Depends on lnpks_pkg, lnpks_sdiv and last_note_priority_key_stack_top_assert.svh.
//
//   port group   dir  handshake                     payload
//   s_axis       in   s_axis_tvalid/s_axis_tready   tuser: command; tdata: key
//   m_axis       out  m_axis_tvalid/m_axis_tready   tuser: note_active; tdata: key, timeout
//   cfg          in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A word reaches the result register from the load state when the stack ends empty or
// the key frequency is zero, else from the divide state after 20 quotient bits and the divider's done flag.
// A release adds a scan of one stack entry per cycle, over up to 8 entries.
// Reset clears the held count and sets every frequency to 440.
// A word waiting on m_axis does not block the next accepted word; the block
// holds in its emit state only until the output register frees.
`default_nettype none
`include "last_note_priority_key_stack_top_assert.svh"

module last_note_priority_key_stack_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,  // [2:0] key, rest zero
  input  wire logic [0:0]                          s_axis_tuser,  // [0] command
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [31:0]                              m_axis_tdata,  // [2:0] current_key,
                                                                  // [27:3] timeout_count
  output logic [0:0]                               m_axis_tuser,  // [0] note_active
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [lnpks_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lnpks_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lnpks_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  key_t               stack_q [STACK_DEPTH];
  key_t               stack_d [STACK_DEPTH];
  logic [FREQ_W-1:0]  freq_q  [NUM_KEYS];

  logic               cmd_q, cmd_d;
  key_t               key_q, key_d;
  logic               res_active_q, res_active_d;
  key_t               res_key_q, res_key_d;
  logic [TIMEOUT_W-1:0] res_timeout_q, res_timeout_d;

  logic               out_valid_q, out_valid_d;
  logic               out_active_q, out_active_d;
  key_t               out_key_q, out_key_d;
  logic [TIMEOUT_W-1:0] out_timeout_q, out_timeout_d;

  logic               push_en, rm_en;
  logic               match, scan_last;
  logic [FREQ_W-1:0]  top_freq;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign match     = (stack_q[idx_q] == key_q);
  assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) >= count_q);
  assign top_freq  = freq_q[stack_q[0]];

  lnpks_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    res_active_d  = res_active_q;
    res_key_d     = res_key_q;
    res_timeout_d = res_timeout_q;
    out_valid_d   = out_valid_q;
    out_active_d  = out_active_q;
    out_key_d     = out_key_q;
    out_timeout_d = out_timeout_q;
    push_en       = 1'b0;
    rm_en         = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = top_freq;
    s_axis_tready = (state_q == ST_IDLE);

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser[0];
          key_d   = s_axis_tdata[KEY_W-1:0];
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        idx_d = '0;
        if (cmd_q == CMD_PRESS) begin
          if (count_q < CNT_W'(STACK_DEPTH)) begin
            push_en = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          state_d = ST_LOAD;
        end else if (count_q == '0) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          rm_en   = 1'b1;
          count_d = count_q - CNT_W'(1);
          state_d = ST_LOAD;
        end else if (scan_last) begin
          state_d = ST_LOAD;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_LOAD: begin
        res_key_d    = stack_q[0];
        res_active_d = (count_q != '0);
        if (count_q == '0) begin
          res_key_d     = '0;
          res_timeout_d = '0;
          state_d       = ST_EMIT;
        end else if (top_freq == '0) begin
          res_timeout_d = TIMEOUT_W'(DAC_CLOCK_HZ);
          state_d       = ST_EMIT;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_timeout_d = TIMEOUT_W'(div_rsp.quotient);
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_active_d  = res_active_q;
          out_key_d     = res_key_q;
          out_timeout_d = res_timeout_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // push shifts every entry up; remove closes the gap above the match
  always_comb begin
    for (int j = 0; j < STACK_DEPTH; j++) begin
      stack_d[j] = stack_q[j];
    end
    if (push_en) begin
      stack_d[0] = key_q;
      for (int j = 1; j < STACK_DEPTH; j++) begin
        stack_d[j] = stack_q[j-1];
      end
    end else if (rm_en) begin
      for (int j = 0; j < STACK_DEPTH - 1; j++) begin
        if (IDX_W'(j) >= idx_q) begin
          stack_d[j] = stack_q[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        freq_q[k] <= FREQ_RESET;
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_KEYS))) begin
      freq_q[cfg_index_i[KEY_W-1:0]] <= cfg_data_i[FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < STACK_DEPTH; j++) begin
      stack_q[j] <= stack_d[j];
    end
    cmd_q         <= cmd_d;
    key_q         <= key_d;
    res_active_q  <= res_active_d;
    res_key_q     <= res_key_d;
    res_timeout_q <= res_timeout_d;
    out_active_q  <= out_active_d;
    out_key_q     <= out_key_d;
    out_timeout_q <= out_timeout_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tuser[0] = out_active_q;
  assign m_axis_tdata    = {4'b0, out_timeout_q, out_key_q};

  `LNPKS_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(STACK_DEPTH), "held count beyond stack depth")
  `LNPKS_ASSERT(a_push, clk_i, rst_ni, push_en |=> (stack_q[0] == $past(key_q)) && (count_q == $past(count_q) + CNT_W'(1)), "push did not land on top")
  `LNPKS_ASSERT(a_remove, clk_i, rst_ni, rm_en |=> (count_q == $past(count_q) - CNT_W'(1)), "remove did not drop one entry")
  `LNPKS_ASSERT(a_idle_word, clk_i, rst_ni, (out_valid_q && !out_active_q) |-> (out_key_q == '0) && (out_timeout_q == '0), "empty stack word not zero")
  `LNPKS_ASSERT(a_div_wait, clk_i, rst_ni, div_rsp.done |-> (state_q == ST_DIV), "divider done outside divide wait")

endmodule

`default_nettype wire
